// File: hdl/nonzero_quantile_select_macros.svh
// Assertion macros for the nonzero quantile selector.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef NONZERO_QUANTILE_SELECT_MACROS_SVH
`define NONZERO_QUANTILE_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define NQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define NQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/nqs_pkg.sv
// Shared types and constants of the nonzero quantile selector.
// Used by every RTL module of the block; depends on nothing.
package nqs_pkg;

	localparam int VAL_W      = 31;
	localparam int PERMILLE_W = 10;
	localparam int MINCNT_W   = 11;
	localparam int STATUS_W   = 2;

	// Division by 1000 as a multiply by a rounded-up reciprocal and a shift.
	localparam int             RECIP_SHIFT = 36;
	localparam int             RECIP_W     = 27;
	localparam logic [26:0]    RECIP_MULT  = 27'd68719477;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [1:0] REG_LOW_PERMILLE  = 2'd0;
	localparam logic [1:0] REG_HIGH_PERMILLE = 2'd1;
	localparam logic [1:0] REG_MIN_COUNT     = 2'd2;

	localparam logic [PERMILLE_W-1:0] LOW_PERMILLE_RST  = 10'd50;
	localparam logic [PERMILLE_W-1:0] HIGH_PERMILLE_RST = 10'd850;
	localparam logic [MINCNT_W-1:0]   MIN_COUNT_RST     = 11'd20;

	typedef struct packed {
		logic signed [31:0] cell_value;
		logic               last_cell;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]    low_value;
		logic [VAL_W-1:0]    high_value;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef struct packed {
		logic             occ;
		logic [VAL_W-1:0] val;
		logic             gt;
	} cell_link_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_IDX1,
		S_IDX2,
		S_IDX3,
		S_DRAIN,
		S_DONE
	} state_t;

endpackage

// File: hdl/nonzero_quantile_select.sv
// Top level of the nonzero quantile selector: configuration registers, sequencer, chain.
// Depends on nqs_pkg, nqs_chain, nqs_index and nonzero_quantile_select_macros.svh.
//
// Usage:
// Matrix cells arrive as transactions on item, taken when start is high and busy is
// low. Cells not above zero are discarded; positive ones are inserted into a sorted
// chain of MAX_VALUES cells, one transaction per cycle while busy stays low. Values
// beyond the chain's capacity are dropped and flagged.
// The transaction with last_cell set closes the set: busy rises, a multiply pipeline
// computes the two quantile indices in S_IDX1 to S_IDX3, then, if any value was kept,
// the chain drains one value per cycle from its head. The result is on result with
// done high for one cycle, and busy falls the cycle after. The receiver cannot stall;
// the result must be taken when done is high.
// The user must write low and high permille and the minimum count over the APB port
// only while busy is low; the block itself does not enforce it. Reset clears the chain,
// the count and the overflow flag and loads the register defaults.
`include "nonzero_quantile_select_macros.svh"
module nonzero_quantile_select
	import nqs_pkg::*;
#(
	parameter int MAX_VALUES = 1024
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(MAX_VALUES + 1);
	localparam int IDX_W = $clog2(MAX_VALUES);
	localparam int CMP_W = (CNT_W > MINCNT_W) ? CNT_W : MINCNT_W;

	state_t state_q, state_d;

	logic [PERMILLE_W-1:0] low_permille_q;
	logic [PERMILLE_W-1:0] high_permille_q;
	logic [MINCNT_W-1:0]   min_count_q;
	logic [CNT_W-1:0]      count_q;
	logic                  overflow_q;
	logic [CNT_W-1:0]      pos_q;
	logic [VAL_W-1:0]      low_q, high_q;

	logic                  accept, keep, full, ins, shift, too_few, drain_end;
	logic [VAL_W-1:0]      head_value;
	logic [IDX_W-1:0]      idx_lo, idx_hi;
	logic [1:0]            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_permille_q  <= LOW_PERMILLE_RST;
			high_permille_q <= HIGH_PERMILLE_RST;
			min_count_q     <= MIN_COUNT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_LOW_PERMILLE:  low_permille_q  <= pwdata[PERMILLE_W-1:0];
				REG_HIGH_PERMILLE: high_permille_q <= pwdata[PERMILLE_W-1:0];
				REG_MIN_COUNT:     min_count_q     <= pwdata[MINCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW_PERMILLE:  prdata = 32'(low_permille_q);
			REG_HIGH_PERMILLE: prdata = 32'(high_permille_q);
			REG_MIN_COUNT:     prdata = 32'(min_count_q);
			default:           prdata = '0;
		endcase
	end

	assign accept = start && !busy;
	assign keep   = !item.cell_value[31] && (item.cell_value != 32'sd0);
	assign full   = (count_q == CNT_W'(MAX_VALUES));
	assign ins    = accept && keep && !full;

	nqs_chain #(.MAX_VALUES(MAX_VALUES)) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.insert     (ins),
		.shift      (shift),
		.value      (item.cell_value[VAL_W-1:0]),
		.head_value (head_value)
	);

	nqs_index #(.MAX_VALUES(MAX_VALUES)) u_index (
		.clk           (clk),
		.count         (count_q),
		.low_permille  (low_permille_q),
		.high_permille (high_permille_q),
		.idx_lo        (idx_lo),
		.idx_hi        (idx_hi)
	);

	assign drain_end = (pos_q == count_q - CNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && item.last_cell) state_d = S_IDX1;
			S_IDX1:  state_d = S_IDX2;
			S_IDX2:  state_d = S_IDX3;
			S_IDX3:  state_d = (count_q == '0) ? S_DONE : S_DRAIN;
			S_DRAIN: if (drain_end) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy  = (state_q != S_IDLE);
		shift = (state_q == S_DRAIN);
		done  = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			state_q <= state_d;
			if (ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (done) begin
				count_q <= '0;
			end
			if (accept && keep && full) begin
				overflow_q <= 1'b1;
			end else if (done) begin
				overflow_q <= 1'b0;
			end
			pos_q <= shift ? pos_q + CNT_W'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && (pos_q[IDX_W-1:0] == idx_lo)) begin
			low_q <= head_value;
		end
		if (shift && (pos_q[IDX_W-1:0] == idx_hi)) begin
			high_q <= head_value;
		end
	end

	assign too_few = (count_q == '0) || (CMP_W'(count_q) < CMP_W'(min_count_q));

	always_comb begin
		if (too_few) begin
			result = '{low_value: '0, high_value: '0, status: STATUS_TOO_FEW};
		end else begin
			result = '{low_value: low_q, high_value: high_q,
				status: overflow_q ? STATUS_OVERFLOW : STATUS_OK};
		end
	end

	`NQS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_VALUES), "count high")
	`NQS_ASSERT_IMPL(a_overflow_full, clk, arst_n, overflow_q, full, "overflow while not full")
	`NQS_ASSERT_NEXT(a_last_busy, clk, arst_n, accept && item.last_cell, busy, "last not taken")
	`NQS_ASSERT_IMPL(a_drain_pos, clk, arst_n, shift, pos_q < count_q, "drain past the count")
	`NQS_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done && !busy, "done held too long")

endmodule

// File: hdl/nqs_cell.sv
// One cell of the sorted insertion chain: holds one kept value and its occupancy.
// Depends on nqs_pkg.
module nqs_cell
	import nqs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   insert,
	input  logic                   shift,
	input  logic [VAL_W-1:0]       value,
	input  cell_link_t             left,
	input  cell_link_t             right,
	output cell_link_t             link
);

	logic             occ_q;
	logic [VAL_W-1:0] val_q;
	logic             gt;

	assign gt   = occ_q && (val_q > value);
	assign link = '{occ: occ_q, val: val_q, gt: gt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift) begin
			occ_q <= right.occ;
		end else if (insert && !occ_q && left.occ) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= right.val;
		end else if (insert) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (gt || (!occ_q && left.occ)) begin
				val_q <= value;
			end
		end
	end

endmodule

// File: hdl/nqs_chain.sv
// Row of insertion cells that keeps values in ascending order and drains from the head.
// Depends on nqs_pkg and nqs_cell.
module nqs_chain
	import nqs_pkg::*;
#(
	parameter int MAX_VALUES = 1024
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             insert,
	input  logic             shift,
	input  logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] head_value
);

	localparam cell_link_t HEAD_LINK = '{occ: 1'b1, val: '0, gt: 1'b0};
	localparam cell_link_t TAIL_LINK = '{occ: 1'b0, val: '0, gt: 1'b0};

	cell_link_t links [MAX_VALUES];

	for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;

		if (i == 0) begin : g_head
			assign left_link = HEAD_LINK;
		end else begin : g_mid_l
			assign left_link = links[i-1];
		end

		if (i == MAX_VALUES - 1) begin : g_tail
			assign right_link = TAIL_LINK;
		end else begin : g_mid_r
			assign right_link = links[i+1];
		end

		nqs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.insert (insert),
			.shift  (shift),
			.value  (value),
			.left   (left_link),
			.right  (right_link),
			.link   (links[i])
		);
	end

	assign head_value = links[0].val;

endmodule

// File: hdl/nqs_index.sv
// Three-stage pipeline that turns a kept count and two permille fractions into store indices.
// Depends on nqs_pkg.
module nqs_index
	import nqs_pkg::*;
#(
	parameter int MAX_VALUES = 1024
)
(
	input  logic                          clk,
	input  logic [$clog2(MAX_VALUES+1)-1:0] count,
	input  logic [PERMILLE_W-1:0]         low_permille,
	input  logic [PERMILLE_W-1:0]         high_permille,
	output logic [$clog2(MAX_VALUES)-1:0] idx_lo,
	output logic [$clog2(MAX_VALUES)-1:0] idx_hi
);

	localparam int CNT_W  = $clog2(MAX_VALUES + 1);
	localparam int IDX_W  = $clog2(MAX_VALUES);
	localparam int PROD_W = CNT_W + PERMILLE_W;
	localparam int FULL_W = PROD_W + RECIP_W;
	localparam int Q_W    = CNT_W + 1;

	logic [PROD_W-1:0] prod_lo_s1, prod_hi_s1;
	logic [FULL_W-1:0] full_lo_s2, full_hi_s2;
	logic [Q_W-1:0]    q_lo, q_hi;
	logic [IDX_W-1:0]  idx_lo_s3, idx_hi_s3;
	logic [IDX_W-1:0]  top_idx;

	assign q_lo    = full_lo_s2[RECIP_SHIFT +: Q_W];
	assign q_hi    = full_hi_s2[RECIP_SHIFT +: Q_W];
	assign top_idx = IDX_W'(count - CNT_W'(1));

	always_ff @(posedge clk) begin
		prod_lo_s1 <= PROD_W'(count) * PROD_W'(low_permille);
		prod_hi_s1 <= PROD_W'(count) * PROD_W'(high_permille);
		full_lo_s2 <= FULL_W'(prod_lo_s1) * FULL_W'(RECIP_MULT);
		full_hi_s2 <= FULL_W'(prod_hi_s1) * FULL_W'(RECIP_MULT);
		idx_lo_s3  <= (q_lo >= Q_W'(count)) ? top_idx : IDX_W'(q_lo);
		idx_hi_s3  <= (q_hi >= Q_W'(count)) ? top_idx : IDX_W'(q_hi);
	end

	assign idx_lo = idx_lo_s3;
	assign idx_hi = idx_hi_s3;

endmodule

// File: tb/tb_nonzero_quantile_select.sv
// Self-checking testbench for nonzero_quantile_select: streams signed Q24.8 cells in sets,
// keeps its own sorted copy of the positive cells and checks both quantiles and the status.
// Depends on nqs_pkg and the nonzero_quantile_select RTL; reads and writes no files.
module tb_nonzero_quantile_select;
	timeunit 1ns;
	timeprecision 1ps;
	import nqs_pkg::*;

	localparam int STORE_DEPTH  = 1024;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 700;
	localparam int DIR_ROWS     = 18;
	localparam int SPLIT_A      = 4;
	localparam int SPLIT_B      = 14;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] cval;
		bit          last;
		bit          typed;
		out_item_t   want;
	} cell_row_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	in_item_t    item    = '0;
	logic        done;
	out_item_t   result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [PERMILLE_W-1:0] cfg_low  = LOW_PERMILLE_RST;
	logic [PERMILLE_W-1:0] cfg_high = HIGH_PERMILLE_RST;
	logic [MINCNT_W-1:0]   cfg_min  = MIN_COUNT_RST;

	bit [VAL_W-1:0] kept_sorted[$];
	bit             kept_overflow = 1'b0;
	out_item_t      pending_quantiles[$];
	cell_row_t      dir_rows[DIR_ROWS];

	int mismatches = 0;
	int cycles     = 0;
	int cells_sent = 0;
	int sets_sent  = 0;
	int cfg_rounds = 0;
	int n_ok       = 0;
	int n_too_few  = 0;
	int n_overflow = 0;

	always #2 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	nonzero_quantile_select #(.MAX_VALUES(STORE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic cell_row_t mk_row(input logic [31:0] cval, input bit last,
		input bit typed, input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
		input logic [STATUS_W-1:0] st);
		cell_row_t r;
		r.cval  = cval;
		r.last  = last;
		r.typed = typed;
		r.want  = '{lo, hi, st};
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] value_at(input logic [PERMILLE_W-1:0] permille);
		longint unsigned cnt;
		longint unsigned idx;
		cnt = kept_sorted.size();
		idx = (cnt * permille) / 1000;
		if (idx >= cnt)
			idx = cnt - 1;
		return kept_sorted[idx];
	endfunction

	task automatic insert_and_select(input in_item_t c, output bit closes, output out_item_t r);
		int pos;
		bit [VAL_W-1:0] v;
		closes = c.last_cell;
		r = '0;
		if (!c.cell_value[31] && c.cell_value != 0) begin
			v = c.cell_value[30:0];
			if (kept_sorted.size() >= STORE_DEPTH) begin
				kept_overflow = 1'b1;
			end else begin
				pos = kept_sorted.size();
				while (pos > 0 && kept_sorted[pos-1] > v)
					pos--;
				kept_sorted.insert(pos, v);
			end
		end
		if (c.last_cell) begin
			if (kept_sorted.size() == 0 || kept_sorted.size() < cfg_min) begin
				r.status = STATUS_TOO_FEW;
			end else begin
				r.low_value  = value_at(cfg_low);
				r.high_value = value_at(cfg_high);
				r.status     = kept_overflow ? STATUS_OVERFLOW : STATUS_OK;
			end
			kept_sorted.delete();
			kept_overflow = 1'b0;
		end
	endtask

	function automatic int draw_gap(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return $urandom_range(0, 16);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
	endfunction

	function automatic logic [31:0] random_cell();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, 40);
			2, 3, 4: return {1'b0, r[30:0]};
			5: return 32'h0;
			6, 7: return {1'b1, r[30:0]};
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h0000_0001;
					2: return 32'h8000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return r;
		endcase
	endfunction

	function automatic logic [31:0] random_positive();
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 200);
		return (r[30:0] == 0) ? 32'h1 : {1'b0, r[30:0]};
	endfunction

	task automatic send_cell(input logic [31:0] cval, input bit last, input int gap,
		input bit typed, input out_item_t want);
		in_item_t  c;
		bit        closes;
		out_item_t r;
		out_item_t expected;
		c.cell_value = cval;
		c.last_cell  = last;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= c;
		do @(posedge clk); while (busy);
		insert_and_select(c, closes, r);
		if (closes) begin
			expected = typed ? want : r;
			pending_quantiles = {pending_quantiles, expected};
			sets_sent++;
		end
		cells_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained(input int settle);
		start <= 1'b0;
		while (pending_quantiles.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LOW_PERMILLE:  cfg_low  = data[PERMILLE_W-1:0];
			REG_HIGH_PERMILLE: cfg_high = data[PERMILLE_W-1:0];
			REG_MIN_COUNT:     cfg_min  = data[MINCNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_registers();
		apb_read_check(REG_LOW_PERMILLE, 32'(cfg_low));
		apb_read_check(REG_HIGH_PERMILLE, 32'(cfg_high));
		apb_read_check(REG_MIN_COUNT, 32'(cfg_min));
	endtask

	task automatic apply_config(input int low, input int high, input int minc);
		logic [31:0] junk;
		wait_drained(8);
		junk = $urandom;
		apb_write(REG_LOW_PERMILLE, {junk[31:PERMILLE_W], 10'(low)});
		junk = $urandom;
		apb_write(REG_HIGH_PERMILLE, {junk[31:PERMILLE_W], 10'(high)});
		junk = $urandom;
		apb_write(REG_MIN_COUNT, {junk[31:MINCNT_W], 11'(minc)});
		check_registers();
		cfg_rounds++;
	endtask

	task automatic random_config();
		case ($urandom_range(0, 5))
			0: apply_config(0, 0, 1);
			1: apply_config(999, 999, 1);
			2: apply_config(1023, 1023, $urandom_range(0, 8));
			3: apply_config(0, 1023, ($urandom_range(0, 1) == 0) ? 1024 : 2047);
			default: apply_config($urandom_range(0, 1023), $urandom_range(0, 1023),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 16));
		endcase
	endtask

	task automatic run_big_set(input int positives, input int minc);
		int          n;
		int          mode;
		bit          pos;
		logic [31:0] c;
		apply_config($urandom_range(0, 1023), $urandom_range(0, 1023), minc);
		mode = ($urandom_range(0, 1) == 0) ? 0 : 2;
		n = 0;
		while (n < positives) begin
			pos = ($urandom_range(0, 7) != 0);
			if (pos) begin
				c = random_positive();
				n++;
			end else begin
				c = $urandom;
				c = c[0] ? {1'b1, c[30:0]} : 32'h0;
			end
			send_cell(c, pos && n == positives, draw_gap(mode), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_quantiles.size() == 0) begin
				report_mismatch("result with no transaction waiting for it");
			end else begin
				want = pending_quantiles.pop_front();
				if (result.low_value !== want.low_value)
					report_mismatch($sformatf("low_value %h, expected %h",
						result.low_value, want.low_value));
				if (result.high_value !== want.high_value)
					report_mismatch($sformatf("high_value %h, expected %h",
						result.high_value, want.high_value));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, want.status));
				case (want.status)
					STATUS_OK:       n_ok++;
					STATUS_TOO_FEW:  n_too_few++;
					default:         n_overflow++;
				endcase
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int len;
		int mode;
		int set_no;
		dir_rows[0]  = mk_row(32'h0000_0000, 1, 1, '0, '0, STATUS_TOO_FEW);
		dir_rows[1]  = mk_row(32'hFFFF_FFFF, 1, 1, '0, '0, STATUS_TOO_FEW);
		dir_rows[2]  = mk_row(32'h8000_0000, 1, 1, '0, '0, STATUS_TOO_FEW);
		dir_rows[3]  = mk_row(32'h7FFF_FFFF, 1, 1, '0, '0, STATUS_TOO_FEW);
		dir_rows[4]  = mk_row(32'h7FFF_FFFF, 1, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, STATUS_OK);
		dir_rows[5]  = mk_row(32'h0000_0001, 1, 1, 31'h1, 31'h1, STATUS_OK);
		dir_rows[6]  = mk_row(32'h0000_0005, 0, 0, '0, '0, STATUS_OK);
		dir_rows[7]  = mk_row(32'hFFFF_FFFD, 0, 0, '0, '0, STATUS_OK);
		dir_rows[8]  = mk_row(32'h0000_0000, 0, 0, '0, '0, STATUS_OK);
		dir_rows[9]  = mk_row(32'h0000_0002, 0, 0, '0, '0, STATUS_OK);
		dir_rows[10] = mk_row(32'h7FFF_FFFF, 0, 0, '0, '0, STATUS_OK);
		dir_rows[11] = mk_row(32'h0000_0003, 1, 0, '0, '0, STATUS_OK);
		dir_rows[12] = mk_row(32'h0000_0100, 0, 0, '0, '0, STATUS_OK);
		dir_rows[13] = mk_row(32'h8000_0001, 1, 0, '0, '0, STATUS_OK);
		dir_rows[14] = mk_row(32'h0000_0000, 1, 1, '0, '0, STATUS_TOO_FEW);
		dir_rows[15] = mk_row(32'h4000_0000, 0, 0, '0, '0, STATUS_OK);
		dir_rows[16] = mk_row(32'h0000_0080, 0, 0, '0, '0, STATUS_OK);
		dir_rows[17] = mk_row(32'h4000_0000, 1, 0, '0, '0, STATUS_OK);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_registers();

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == SPLIT_A) begin
				wait_drained(8);
				apb_write(REG_UNUSED, 32'h0000_03FF);
				check_registers();
				apply_config(0, 1023, 1);
			end
			if (i == SPLIT_B)
				apply_config(999, 500, 0);
			send_cell(dir_rows[i].cval, dir_rows[i].last, i % 4, dir_rows[i].typed,
				dir_rows[i].want);
		end

		set_no = 0;
		while (cells_sent < DIR_ROWS + RANDOM_ITEMS) begin
			if (set_no % 8 == 0)
				random_config();
			mode = $urandom_range(0, 2);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
			for (int k = 1; k <= len; k++)
				send_cell(random_cell(), k == len, draw_gap(mode), 1'b0, '0);
			set_no++;
		end

		// Full store, overflow with enough values, and overflow that still has too few.
		run_big_set(STORE_DEPTH, 1024);
		run_big_set(STORE_DEPTH + 6, 1024);
		run_big_set(STORE_DEPTH + 2, 2047);

		wait_drained(20);
		$display("Sent %0d cells in %0d sets over %0d register settings.",
			cells_sent, sets_sent, cfg_rounds);
		$display("Results checked: %0d ok, %0d too few, %0d overflow; %0d mismatches.",
			n_ok, n_too_few, n_overflow, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
